@@ hdl/xhc_pkg.sv @@
// shared types and constants for the hash chain append block
package xhc_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam logic [7:0] ACC_SEED = 8'hA5;

  typedef enum logic [1:0] {
    PART_PARENT  = 2'd0,
    PART_PAYLOAD = 2'd1,
    PART_NODE    = 2'd2
  } part_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hdl/xor_hash_chain_append.sv @@
// top level of the hash chain append block
//
// message channel: one item per transaction on msg_valid / msg_stall, carrying
// data_byte with byte_valid, last and timestamp; a byte is folded into the
// payload accumulator, and last closes the message and appends a node
// word channel: each node gives 3 * HASH_BYTES / 8 transactions on
// word_valid / word_stall (12 at 32 bytes): parent, payload, node hash,
// lowest word first, end_of_node on the final word
// throughput: one message item per cycle while msg_stall is low; the word
// side gives one word per cycle while word_stall does not hold it
// a node record is queued with its last item and read out from the queue head
// a two-entry queue of node records sits between front and back, so the
// message side only stalls once two appended nodes are still draining
// when word_stall is high on a valid word the register holds and the back end
// waits; the front keeps folding bytes meanwhile unless the queue is full
// reset: accumulator back to its start pattern, root and node count zero,
// queue and word register empty; no clearing pass
module xor_hash_chain_append
  import xhc_pkg::*;
#(
  parameter int unsigned HASH_BYTES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  logic [7:0]            data_byte,
  input  logic                  byte_valid,
  input  logic                  last,
  input  logic [WORD_BITS-1:0]  timestamp,
  output logic                  word_valid,
  input  logic                  word_stall,
  output logic [WORD_BITS-1:0]  node_number,
  output logic [WORD_BITS-1:0]  node_time,
  output logic [1:0]            part,
  output logic [1:0]            word_index,
  output logic [WORD_BITS-1:0]  hash_word,
  output logic                  end_of_node
);

  localparam int unsigned REC_W = 3 * HASH_BYTES * 8 + 2 * WORD_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;

  queue_status_t    q_status;
  logic             push;
  logic             pop;
  logic [REC_W-1:0] push_data;
  logic [REC_W-1:0] head;

  xhc_front #(
    .HASH_BYTES (HASH_BYTES),
    .REC_W      (REC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .timestamp  (timestamp),
    .q_status   (q_status),
    .push       (push),
    .push_data  (push_data)
  );

  xhc_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  xhc_back #(
    .HASH_BYTES (HASH_BYTES),
    .REC_W      (REC_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .head        (head),
    .pop         (pop),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .node_number (node_number),
    .node_time   (node_time),
    .part        (part),
    .word_index  (word_index),
    .hash_word   (hash_word),
    .end_of_node (end_of_node)
  );

endmodule

@@ hdl/xhc_front.sv @@
// front end: byte folding, node hash forming and chain state
module xhc_front
  import xhc_pkg::*;
#(
  parameter int unsigned HASH_BYTES = 32,
  parameter int unsigned REC_W = 3 * HASH_BYTES * 8 + 2 * WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  logic [7:0]            data_byte,
  input  logic                  byte_valid,
  input  logic                  last,
  input  logic [WORD_BITS-1:0]  timestamp,
  input  queue_status_t         q_status,
  output logic                  push,
  output logic [REC_W-1:0]      push_data
);

  localparam int unsigned HB_BITS = HASH_BYTES * 8;
  localparam int unsigned POS_W = $clog2(HASH_BYTES);

  logic [HB_BITS-1:0]   acc;
  logic [HB_BITS-1:0]   acc_folded;
  logic [HB_BITS-1:0]   seed;
  logic [HB_BITS-1:0]   root;
  logic [HB_BITS-1:0]   node;
  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;
  logic [WORD_BITS-1:0] counter;
  logic                 accept;

  for (genvar i = 0; i < HASH_BYTES; i++) begin : g_byte
    assign seed[8*i +: 8] = 8'(i) ^ ACC_SEED;
    assign acc_folded[8*i +: 8] = acc[8*i +: 8] ^
        ((byte_valid && (pos == POS_W'(i))) ? data_byte : 8'h00);
  end

  assign node = root ^ acc_folded ^ HB_BITS'({counter, timestamp});

  assign msg_stall = q_status.full;
  assign accept = msg_valid && !q_status.full;
  assign push = accept && last;
  assign push_data = {timestamp, counter, node, acc_folded, root};

  assign pos_next = (pos == POS_W'(HASH_BYTES - 1)) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= seed;
      pos <= '0;
      root <= '0;
      counter <= '0;
    end else if (accept) begin
      if (last) begin
        acc <= seed;
        pos <= '0;
        root <= node;
        counter <= counter + 1'b1;
      end else if (byte_valid) begin
        acc <= acc_folded;
        pos <= pos_next;
      end
    end
  end

endmodule

@@ hdl/xhc_queue.sv @@
// short register queue of finished node records
module xhc_queue
  import xhc_pkg::*;
#(
  parameter int unsigned WIDTH = 896,
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [WIDTH-1:0]  push_data,
  input  logic              pop,
  output logic [WIDTH-1:0]  head,
  output queue_status_t     status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head = slots[rd_ptr];
  assign status.full = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/xhc_back.sv @@
// back end: walks a node record and drives the word output register
module xhc_back
  import xhc_pkg::*;
#(
  parameter int unsigned HASH_BYTES = 32,
  parameter int unsigned REC_W = 3 * HASH_BYTES * 8 + 2 * WORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  queue_status_t         q_status,
  input  logic [REC_W-1:0]      head,
  output logic                  pop,
  output logic                  word_valid,
  input  logic                  word_stall,
  output logic [WORD_BITS-1:0]  node_number,
  output logic [WORD_BITS-1:0]  node_time,
  output logic [1:0]            part,
  output logic [1:0]            word_index,
  output logic [WORD_BITS-1:0]  hash_word,
  output logic                  end_of_node
);

  localparam int unsigned HB_BITS = HASH_BYTES * 8;
  localparam int unsigned HASH_WORDS = HASH_BYTES / 8;
  localparam int unsigned WORD_W = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;

  part_t              cur_part;
  part_t              cur_part_next;
  logic [WORD_W-1:0]  cur_word;
  logic [HB_BITS-1:0] sel_hash;
  logic               load;
  logic               last_word;

  assign load = !q_status.empty && (!word_valid || !word_stall);
  assign last_word = (cur_part == PART_NODE) && (cur_word == WORD_W'(HASH_WORDS - 1));
  assign pop = load && last_word;

  always_comb begin
    case (cur_part)
      PART_PARENT:  sel_hash = head[0 +: HB_BITS];
      PART_PAYLOAD: sel_hash = head[HB_BITS +: HB_BITS];
      PART_NODE:    sel_hash = head[2*HB_BITS +: HB_BITS];
      default:      sel_hash = '0;
    endcase
  end

  always_comb begin
    case (cur_part)
      PART_PARENT:  cur_part_next = PART_PAYLOAD;
      PART_PAYLOAD: cur_part_next = PART_NODE;
      PART_NODE:    cur_part_next = PART_PARENT;
      default:      cur_part_next = PART_PARENT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      cur_part <= PART_PARENT;
      cur_word <= '0;
    end else if (load) begin
      word_valid <= 1'b1;
      if (cur_word == WORD_W'(HASH_WORDS - 1)) begin
        cur_word <= '0;
        cur_part <= cur_part_next;
      end else begin
        cur_word <= cur_word + 1'b1;
      end
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      node_number <= head[3*HB_BITS +: WORD_BITS];
      node_time <= head[3*HB_BITS + WORD_BITS +: WORD_BITS];
      part <= cur_part;
      word_index <= 2'(cur_word);
      hash_word <= sel_hash[cur_word*WORD_BITS +: WORD_BITS];
      end_of_node <= last_word;
    end
  end

endmodule

@@ hdl/xhc_checker.sv @@
// port-level checks for the hash chain append block, bound to the top level
module xhc_checker
  import xhc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  msg_stall,
  input logic                  word_valid,
  input logic                  word_stall,
  input logic [WORD_BITS-1:0]  node_number,
  input logic [WORD_BITS-1:0]  node_time,
  input logic [1:0]            part,
  input logic [1:0]            word_index,
  input logic [WORD_BITS-1:0]  hash_word,
  input logic                  end_of_node
);

  // reset leaves the word side empty and the message side open
  a_reset_clear : assert property (@(posedge clk)
      rst |=> !word_valid && !msg_stall)
    else $error("word or message side not clear after reset");

  // a stalled word transaction holds
  a_word_hold : assert property (@(posedge clk) disable iff (rst)
      word_valid && word_stall |=> word_valid && $stable(hash_word) &&
      $stable(node_number) && $stable(node_time) && $stable(part) &&
      $stable(word_index))
    else $error("stalled word changed");

  // the words of one node leave without gaps
  a_no_gap : assert property (@(posedge clk) disable iff (rst)
      word_valid && !word_stall && !end_of_node |=> word_valid)
    else $error("gap inside a node run");

  // end of node only on the node hash part
  a_end_part : assert property (@(posedge clk) disable iff (rst)
      word_valid && end_of_node |-> part == PART_NODE)
    else $error("end_of_node outside the node hash");

  // a node run starts with the parent hash after a closed run
  a_run_start : assert property (@(posedge clk) disable iff (rst)
      word_valid && !word_stall && end_of_node |=>
      !word_valid || (part == PART_PARENT && word_index == 2'd0))
    else $error("node run does not start at parent word zero");

endmodule

bind xor_hash_chain_append xhc_checker u_xhc_checker (.*);
